### rtl/data_group_header_parser_top_defines.svh
// Assertion macros used by the checker file of the data group header parser.
`ifndef DATA_GROUP_HEADER_PARSER_TOP_DEFINES_SVH
`define DATA_GROUP_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DGH_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("dgh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DGH_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("dgh assertion failed");

`endif

### rtl/dgh_pkg.sv
package dgh_pkg;

	localparam int unsigned DEF_MAX_GROUP_LENGTH = 8192;
	localparam int unsigned MIN_GROUP_LENGTH     = 5;
	localparam int unsigned OUT_FIFO_DEPTH       = 4;

	// Result kinds.
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_ADDR    = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// Summary status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_TRUNC    = 2'd2;
	localparam logic [1:0] ST_ADDR_LEN = 2'd3;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [7:0]  payload_byte;
		logic [4:0]  header_flags;
		logic [3:0]  group_type;
		logic [3:0]  continuity_index;
		logic [3:0]  repetition_index;
		logic [15:0] extension_word;
		logic        segment_is_last;
		logic [14:0] segment_number;
		logic [15:0] transport_ident;
		logic [15:0] received_crc;
		logic [1:0]  status;
	} out_item_t;

	// Queue write request: first and second result of one parsed word.
	typedef struct packed {
		logic push0;
		logic push1;
	} push_t;

endpackage

### rtl/dgh_fifo.sv
module dgh_fifo #(
	parameter int unsigned DEPTH = dgh_pkg::OUT_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dgh_pkg::push_t    push,
	input  dgh_pkg::out_item_t item0,
	input  dgh_pkg::out_item_t item1,
	input  logic              pop,
	output dgh_pkg::out_item_t head,
	output logic              not_empty,
	output logic              room2
);
	import dgh_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	out_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_next;

	assign wr_next   = wr_q + PTR_W'(1);
	assign head      = mem_q[rd_q];
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_q] <= item0;
		end
		if (push.push1) begin
			mem_q[wr_next] <= item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.push0) + PTR_W'(push.push1);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
		end
	end

endmodule

### rtl/dgh_parse.sv
module dgh_parse #(
	parameter int unsigned MAX_GROUP_LENGTH = dgh_pkg::DEF_MAX_GROUP_LENGTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output dgh_pkg::push_t     push,
	output dgh_pkg::out_item_t item0,
	output dgh_pkg::out_item_t item1
);
	import dgh_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_GROUP_LENGTH + 1);

	typedef enum logic [3:0] {
		PH_H0, PH_H1, PH_EXT0, PH_EXT1, PH_SEG0, PH_SEG1, PH_UA,
		PH_TID0, PH_TID1, PH_ADDR, PH_DATA, PH_SINK
	} phase_t;

	logic [IDX_W-1:0] idx_q, idx_n;
	phase_t           phase_q, nxt;
	logic [4:0]       flags_q, flags_n;
	logic [11:0]      tni_q, tni_n;
	logic [15:0]      ext_q, ext_n;
	logic [15:0]      seg_q, seg_n;
	logic [15:0]      tid_q, tid_n;
	logic [3:0]       abl_q, abl_n;
	logic [7:0]       tail0_q, tail0_n;
	logic [7:0]       tail1_q, tail1_n;
	logic [1:0]       tcnt_q, tcnt_n;
	logic             err_q, err_n;
	logic             crc_on;
	logic             emit;
	logic [1:0]       emit_kind;
	logic [7:0]       emit_byte;
	logic [1:0]       st;
	logic [15:0]      crcv;
	out_item_t        data_item;
	out_item_t        sum_item;

	// First flagged optional header section at or after the given phase, else the data phase.
	function automatic phase_t next_section(input phase_t from, input logic [4:0] fl);
		phase_t r;
		if (from <= PH_EXT0 && fl[4]) begin
			r = PH_EXT0;
		end else if (from <= PH_SEG0 && fl[2]) begin
			r = PH_SEG0;
		end else if (from <= PH_UA && fl[1]) begin
			r = PH_UA;
		end else begin
			r = PH_DATA;
		end
		return r;
	endfunction

	assign crc_on = flags_q[3];

	always_comb begin
		idx_n     = (idx_q < IDX_W'(MAX_GROUP_LENGTH)) ? idx_q + IDX_W'(1) : idx_q;
		nxt       = phase_q;
		flags_n   = flags_q;
		tni_n     = tni_q;
		ext_n     = ext_q;
		seg_n     = seg_q;
		tid_n     = tid_q;
		abl_n     = abl_q;
		tail0_n   = tail0_q;
		tail1_n   = tail1_q;
		tcnt_n    = tcnt_q;
		err_n     = err_q;
		emit      = 1'b0;
		emit_kind = KIND_DATA;
		emit_byte = data_byte;
		st        = ST_OK;
		crcv      = '0;

		case (phase_q)
			PH_H0: begin
				flags_n = {data_byte[7:4], 1'b0};
				tni_n   = {data_byte[3:0], 8'h00};
				nxt     = PH_H1;
			end
			PH_H1: begin
				tni_n = {tni_q[11:8], data_byte};
				nxt   = next_section(PH_EXT0, flags_q);
			end
			PH_EXT0: begin
				ext_n = {data_byte, 8'h00};
				nxt   = PH_EXT1;
			end
			PH_EXT1: begin
				ext_n = {ext_q[15:8], data_byte};
				nxt   = next_section(PH_SEG0, flags_q);
			end
			PH_SEG0: begin
				seg_n = {data_byte, 8'h00};
				nxt   = PH_SEG1;
			end
			PH_SEG1: begin
				seg_n = {seg_q[15:8], data_byte};
				nxt   = next_section(PH_UA, flags_q);
			end
			PH_UA: begin
				flags_n[0] = flags_q[0] | data_byte[4];
				abl_n      = data_byte[3:0];
				if (data_byte[4]) begin
					nxt = PH_TID0;
				end else begin
					nxt = (data_byte[3:0] != '0) ? PH_ADDR : PH_DATA;
				end
			end
			PH_TID0: begin
				tid_n = {data_byte, 8'h00};
				nxt   = PH_TID1;
			end
			PH_TID1: begin
				tid_n = {tid_q[15:8], data_byte};
				if (abl_q < 4'd2) begin
					err_n = 1'b1;
					nxt   = PH_SINK;
				end else begin
					abl_n = abl_q - 4'd2;
					nxt   = (abl_n != '0) ? PH_ADDR : PH_DATA;
				end
			end
			PH_ADDR: begin
				emit      = !last_byte;
				emit_kind = KIND_ADDR;
				if (abl_q != '0) begin
					abl_n = abl_q - 4'd1;
				end
				nxt = (abl_n != '0) ? PH_ADDR : PH_DATA;
			end
			PH_DATA: begin
				if (!last_byte) begin
					if (!crc_on) begin
						emit = 1'b1;
					end else if (tcnt_q < 2'd2) begin
						if (tcnt_q == 2'd0) begin
							tail0_n = data_byte;
						end else begin
							tail1_n = data_byte;
						end
						tcnt_n = tcnt_q + 2'd1;
					end else begin
						emit      = 1'b1;
						emit_byte = tail0_q;
						tail0_n   = tail1_q;
						tail1_n   = data_byte;
					end
				end
			end
			default: begin
				nxt = PH_SINK;
			end
		endcase

		if (last_byte) begin
			if (idx_n < IDX_W'(MIN_GROUP_LENGTH)) begin
				st = ST_SHORT;
			end else if (err_n) begin
				st = ST_ADDR_LEN;
			end else if (phase_q == PH_ADDR) begin
				st = ST_TRUNC;
			end else if (nxt >= PH_EXT0 && nxt <= PH_ADDR) begin
				st = ST_TRUNC;
			end else if (crc_on && (phase_q != PH_DATA || tcnt_q == 2'd0)) begin
				st = ST_TRUNC;
			end
			// A clean data-phase ending releases the final data word, and with
			// CRC present the last two words form the received CRC.
			if (st == ST_OK && phase_q == PH_DATA) begin
				if (!crc_on) begin
					emit = 1'b1;
				end else begin
					crcv = {((tcnt_q == 2'd2) ? tail1_q : tail0_q), data_byte};
					if (tcnt_q == 2'd2) begin
						emit      = 1'b1;
						emit_byte = tail0_q;
					end
				end
			end
		end
	end

	always_comb begin
		data_item              = '0;
		data_item.item_kind    = emit_kind;
		data_item.payload_byte = emit_byte;

		sum_item                  = '0;
		sum_item.item_kind        = KIND_SUMMARY;
		sum_item.header_flags     = flags_n;
		sum_item.group_type       = tni_n[11:8];
		sum_item.continuity_index = tni_n[7:4];
		sum_item.repetition_index = tni_n[3:0];
		sum_item.extension_word   = ext_n;
		sum_item.segment_is_last  = seg_n[15];
		sum_item.segment_number   = seg_n[14:0];
		sum_item.transport_ident  = tid_n;
		sum_item.received_crc     = crcv;
		sum_item.status           = st;
	end

	assign push.push0 = fire && (emit || last_byte);
	assign push.push1 = fire && emit && last_byte;
	assign item0      = emit ? data_item : sum_item;
	assign item1      = sum_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			phase_q <= PH_H0;
			flags_q <= '0;
			tni_q   <= '0;
			ext_q   <= '0;
			seg_q   <= '0;
			tid_q   <= '0;
			abl_q   <= '0;
			tail0_q <= '0;
			tail1_q <= '0;
			tcnt_q  <= '0;
			err_q   <= 1'b0;
		end else if (fire) begin
			if (last_byte) begin
				idx_q   <= '0;
				phase_q <= PH_H0;
				flags_q <= '0;
				tni_q   <= '0;
				ext_q   <= '0;
				seg_q   <= '0;
				tid_q   <= '0;
				abl_q   <= '0;
				tail0_q <= '0;
				tail1_q <= '0;
				tcnt_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				idx_q   <= idx_n;
				phase_q <= nxt;
				flags_q <= flags_n;
				tni_q   <= tni_n;
				ext_q   <= ext_n;
				seg_q   <= seg_n;
				tid_q   <= tid_n;
				abl_q   <= abl_n;
				tail0_q <= tail0_n;
				tail1_q <= tail1_n;
				tcnt_q  <= tcnt_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

### rtl/data_group_header_parser_top.sv
// Data group header parser.
// The input channel (in_valid/in_ready) carries one word per byte of a data
// group, with last_byte set on the final word. The output channel
// (out_valid/out_ready) carries result words: data-field bytes, end-user
// address bytes, and one group summary with header fields and a status at
// the end of every group.
// An accepted word is held in an input register, then parsed by the header
// state machine, and its results are written into a four-entry result
// queue. The first result of a word reaches the output port once the parser
// has written it from the input register into the queue.
// Throughput is one input word per cycle as long as the receiver drains the
// queue. A final word may produce two results (the released data byte and
// the summary), so the parser only advances while the queue has room for two.
// When the receiver stalls, the queue fills, the input register holds its
// word and in_ready falls; nothing is dropped. When the CRC flag is set, the
// last two data bytes are held back and reported in the summary.
// Reset clears the queue, empties the input register and returns the parser
// to the first header byte of a new group.
module data_group_header_parser_top #(
	parameter int unsigned MAX_GROUP_LENGTH = dgh_pkg::DEF_MAX_GROUP_LENGTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  item_kind,
	output logic [7:0]  payload_byte,
	output logic [4:0]  header_flags,
	output logic [3:0]  group_type,
	output logic [3:0]  continuity_index,
	output logic [3:0]  repetition_index,
	output logic [15:0] extension_word,
	output logic        segment_is_last,
	output logic [14:0] segment_number,
	output logic [15:0] transport_ident,
	output logic [15:0] received_crc,
	output logic [1:0]  status
);
	import dgh_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room2;
	logic       adv;
	logic       in_fire;
	push_t      push;
	out_item_t  item0;
	out_item_t  item1;
	out_item_t  head;

	// The input register moves into the parser only when the queue can take
	// both results that a final word may produce.
	assign adv      = valid_s1 && room2;
	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	dgh_parse #(
		.MAX_GROUP_LENGTH(MAX_GROUP_LENGTH)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.push      (push),
		.item0     (item0),
		.item1     (item1)
	);

	dgh_fifo #(
		.DEPTH(OUT_FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item0     (item0),
		.item1     (item1),
		.pop       (out_valid && out_ready),
		.head      (head),
		.not_empty (out_valid),
		.room2     (room2)
	);

	assign item_kind        = head.item_kind;
	assign payload_byte     = head.payload_byte;
	assign header_flags     = head.header_flags;
	assign group_type       = head.group_type;
	assign continuity_index = head.continuity_index;
	assign repetition_index = head.repetition_index;
	assign extension_word   = head.extension_word;
	assign segment_is_last  = head.segment_is_last;
	assign segment_number   = head.segment_number;
	assign transport_ident  = head.transport_ident;
	assign received_crc     = head.received_crc;
	assign status           = head.status;

endmodule

### rtl/dgh_checker.sv
`include "data_group_header_parser_top_defines.svh"

module dgh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  item_kind,
	input logic [7:0]  payload_byte,
	input logic [4:0]  header_flags,
	input logic [15:0] received_crc,
	input logic [1:0]  status
);
	import dgh_pkg::*;

	// A stalled result word stays offered.
	`DGH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// A stalled result word keeps its kind and byte.
	`DGH_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(item_kind) && $stable(payload_byte))

	// Byte words carry no header, CRC or status.
	`DGH_ASSERT_SAME(a_byte_clean, clk, arst_n, out_valid && item_kind != KIND_SUMMARY, header_flags == '0 && received_crc == '0 && status == ST_OK)

	// A failed group never reports a received CRC.
	`DGH_ASSERT_SAME(a_bad_no_crc, clk, arst_n, out_valid && item_kind == KIND_SUMMARY && status != ST_OK, received_crc == '0)

endmodule

bind data_group_header_parser_top dgh_checker u_dgh_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import dgh_pkg::*;

	// Where the header walk stands before the next word of a group is taken.
	typedef enum logic [3:0] {
		HDR_FIRST, HDR_SECOND, EXT_HI, EXT_LO, SEG_HI, SEG_LO,
		UA_LEN, TID_HI, TID_LO, ADDR_BYTES, DATA_FIELD, DISCARD
	} hdr_section_t;

	// One input word as the driver puts it on the port.
	typedef struct {
		logic [7:0] value;
		logic       final_word;
	} group_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  item_kind;
	logic [7:0]  payload_byte;
	logic [4:0]  header_flags;
	logic [3:0]  group_type;
	logic [3:0]  continuity_index;
	logic [3:0]  repetition_index;
	logic [15:0] extension_word;
	logic        segment_is_last;
	logic [14:0] segment_number;
	logic [15:0] transport_ident;
	logic [15:0] received_crc;
	logic [1:0]  status;

	data_group_header_parser_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.item_kind        (item_kind),
		.payload_byte     (payload_byte),
		.header_flags     (header_flags),
		.group_type       (group_type),
		.continuity_index (continuity_index),
		.repetition_index (repetition_index),
		.extension_word   (extension_word),
		.segment_is_last  (segment_is_last),
		.segment_number   (segment_number),
		.transport_ident  (transport_ident),
		.received_crc     (received_crc),
		.status           (status)
	);

	// Words still to be driven, and the group under construction.
	group_word_t pending_words[$];
	logic [7:0]  grp[$];
	int unsigned word_total = 0;
	int unsigned group_total = 0;

	// Results the parser owes us, oldest first.
	out_item_t results_due[$];

	// Shadow copy of the parser state used for prediction.
	int unsigned  bytes_in_group = 0;
	hdr_section_t cur_section = HDR_FIRST;
	logic [4:0]   hdr_flags = '0;
	logic [11:0]  hdr_type_ci_ri = '0;
	logic [15:0]  ext_field = '0;
	logic [15:0]  seg_field = '0;
	logic [15:0]  tid_field = '0;
	logic [3:0]   addr_remaining = '0;
	logic [7:0]   held_bytes[2];
	int unsigned  held_count = 0;
	logic [1:0]   group_error = ST_OK;

	// Scoreboard bookkeeping.
	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned status_seen[4];

	// Handshake events of the last rising edge, read by the drivers at the falling edge.
	bit in_took = 1'b0;
	bit out_took = 1'b0;

	// Idle control for both sides; a calm side runs without gaps for a stretch.
	int unsigned in_gap = 0;
	int unsigned out_hold = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	// Clock with a 2 ns period.
	initial begin
		forever #1 clk = ~clk;
	end

	// Safety net in case the block stops handshaking.
	initial begin
		#500000;
		$display("data_group_header_parser_top: mismatch");
		$finish;
	end

	task automatic add_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			grp.push_back(8'($urandom_range(0, 255)));
	endtask

	// Move the group under construction into the driver queue, marking its last word.
	task automatic commit_group();
		group_word_t w;
		for (int i = 0; i < grp.size(); i++) begin
			w.value = grp[i];
			w.final_word = (i == grp.size() - 1);
			pending_words.push_back(w);
		end
		word_total += grp.size();
		group_total++;
		grp.delete();
	endtask

	// Mostly well-formed groups with random content, some cut short at a random point.
	task automatic make_random_group();
		logic [7:0] lead;
		logic [7:0] ua;
		int unsigned n_addr;
		int unsigned n_data;
		int unsigned cut;
		lead = 8'($urandom_range(0, 255));
		grp.push_back(lead);
		add_random(1);
		if (lead[7])
			add_random(2);
		if (lead[5])
			add_random(2);
		if (lead[4]) begin
			ua = 8'($urandom_range(0, 255));
			// A transport id with a length below two is kept rare.
			if (ua[4] && ua[3:0] < 2 && $urandom_range(0, 7) != 0)
				ua[3:0] = 4'($urandom_range(2, 15));
			grp.push_back(ua);
			n_addr = ua[3:0];
			if (ua[4]) begin
				add_random(2);
				n_addr = (n_addr >= 2) ? n_addr - 2 : 0;
			end
			add_random(n_addr);
		end
		n_data = ($urandom_range(0, 39) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
		if ($urandom_range(0, 15) == 0)
			n_data = 0;
		if (lead[6])
			n_data += 2;
		add_random(n_data);
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, grp.size());
			while (grp.size() > cut)
				void'(grp.pop_back());
		end
		commit_group();
	endtask

	// Section that follows the current one, given which optional fields are flagged.
	function automatic hdr_section_t section_after(input hdr_section_t from);
		if (from <= EXT_HI && hdr_flags[4])
			return EXT_HI;
		if (from <= SEG_HI && hdr_flags[2])
			return SEG_HI;
		if (from <= UA_LEN && hdr_flags[1])
			return UA_LEN;
		return DATA_FIELD;
	endfunction

	function automatic out_item_t byte_result(input logic [1:0] kind, input logic [7:0] value);
		out_item_t r;
		r = '0;
		r.item_kind = kind;
		r.payload_byte = value;
		return r;
	endfunction

	// Advances the shadow parser by one accepted word and queues what it must emit.
	task automatic parse_word(input logic [7:0] b, input logic last);
		hdr_section_t cur;
		hdr_section_t nxt;
		logic         crc_on;
		logic [1:0]   st;
		logic [15:0]  crc_word;
		out_item_t    sum;
		cur = cur_section;
		nxt = cur;
		crc_on = hdr_flags[3];
		st = ST_OK;
		crc_word = '0;
		if (bytes_in_group < DEF_MAX_GROUP_LENGTH)
			bytes_in_group++;

		case (cur)
			HDR_FIRST: begin
				hdr_flags = {b[7:4], 1'b0};
				hdr_type_ci_ri = {b[3:0], 8'h00};
				nxt = HDR_SECOND;
			end
			HDR_SECOND: begin
				hdr_type_ci_ri[7:0] = b;
				nxt = section_after(EXT_HI);
			end
			EXT_HI: begin
				ext_field = {b, 8'h00};
				nxt = EXT_LO;
			end
			EXT_LO: begin
				ext_field[7:0] = b;
				nxt = section_after(SEG_HI);
			end
			SEG_HI: begin
				seg_field = {b, 8'h00};
				nxt = SEG_LO;
			end
			SEG_LO: begin
				seg_field[7:0] = b;
				nxt = section_after(UA_LEN);
			end
			UA_LEN: begin
				if (b[4])
					hdr_flags[0] = 1'b1;
				addr_remaining = b[3:0];
				if (b[4])
					nxt = TID_HI;
				else
					nxt = (addr_remaining != 0) ? ADDR_BYTES : DATA_FIELD;
			end
			TID_HI: begin
				tid_field = {b, 8'h00};
				nxt = TID_LO;
			end
			TID_LO: begin
				tid_field[7:0] = b;
				// The length byte counts the transport id, so it needs at least two.
				if (addr_remaining < 2) begin
					group_error = ST_ADDR_LEN;
					nxt = DISCARD;
				end else begin
					addr_remaining -= 2;
					nxt = (addr_remaining != 0) ? ADDR_BYTES : DATA_FIELD;
				end
			end
			ADDR_BYTES: begin
				if (!last)
					results_due.push_back(byte_result(KIND_ADDR, b));
				if (addr_remaining > 0)
					addr_remaining--;
				nxt = (addr_remaining != 0) ? ADDR_BYTES : DATA_FIELD;
			end
			DATA_FIELD: begin
				// With a CRC the two newest bytes stay held until the group ends.
				if (!last) begin
					if (!crc_on) begin
						results_due.push_back(byte_result(KIND_DATA, b));
					end else if (held_count < 2) begin
						held_bytes[held_count] = b;
						held_count++;
					end else begin
						results_due.push_back(byte_result(KIND_DATA, held_bytes[0]));
						held_bytes[0] = held_bytes[1];
						held_bytes[1] = b;
					end
				end
			end
			default: nxt = DISCARD;
		endcase
		cur_section = nxt;

		if (last) begin
			if (bytes_in_group < MIN_GROUP_LENGTH)
				st = ST_SHORT;
			else if (group_error == ST_ADDR_LEN)
				st = ST_ADDR_LEN;
			else if (cur == ADDR_BYTES)
				st = ST_TRUNC;
			else if (nxt inside {[EXT_HI:ADDR_BYTES]})
				st = ST_TRUNC;
			else if (crc_on && (cur != DATA_FIELD || held_count == 0))
				st = ST_TRUNC;

			if (st == ST_OK && cur == DATA_FIELD) begin
				if (!crc_on) begin
					results_due.push_back(byte_result(KIND_DATA, b));
				end else begin
					crc_word = {held_bytes[held_count - 1], b};
					if (held_count == 2)
						results_due.push_back(byte_result(KIND_DATA, held_bytes[0]));
				end
			end

			sum = '0;
			sum.item_kind = KIND_SUMMARY;
			sum.header_flags = hdr_flags;
			sum.group_type = hdr_type_ci_ri[11:8];
			sum.continuity_index = hdr_type_ci_ri[7:4];
			sum.repetition_index = hdr_type_ci_ri[3:0];
			sum.extension_word = ext_field;
			sum.segment_is_last = seg_field[15];
			sum.segment_number = seg_field[14:0];
			sum.transport_ident = tid_field;
			sum.received_crc = crc_word;
			sum.status = st;
			results_due.push_back(sum);
			status_seen[st]++;

			// The next group starts from a clean header.
			bytes_in_group = 0;
			cur_section = HDR_FIRST;
			hdr_flags = '0;
			hdr_type_ci_ri = '0;
			ext_field = '0;
			seg_field = '0;
			tid_field = '0;
			addr_remaining = '0;
			held_bytes[0] = '0;
			held_bytes[1] = '0;
			held_count = 0;
			group_error = ST_OK;
		end
	endtask

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
		end
	endtask

	// Compares the word on the output port against the oldest expected result.
	task automatic check_result();
		out_item_t got;
		out_item_t want;
		got = {item_kind, payload_byte, header_flags, group_type, continuity_index,
			repetition_index, extension_word, segment_is_last, segment_number,
			transport_ident, received_crc, status};
		if (results_due.size() == 0) begin
			mismatch_count++;
			$display("%0t: expected no result, got kind %0d byte 0x%0h", $time,
				got.item_kind, got.payload_byte);
		end else begin
			want = results_due.pop_front();
			results_checked++;
			check_field("item_kind", want.item_kind, got.item_kind);
			check_field("payload_byte", want.payload_byte, got.payload_byte);
			check_field("header_flags", want.header_flags, got.header_flags);
			check_field("group_type", want.group_type, got.group_type);
			check_field("continuity_index", want.continuity_index, got.continuity_index);
			check_field("repetition_index", want.repetition_index, got.repetition_index);
			check_field("extension_word", want.extension_word, got.extension_word);
			check_field("segment_is_last", want.segment_is_last, got.segment_is_last);
			check_field("segment_number", want.segment_number, got.segment_number);
			check_field("transport_ident", want.transport_ident, got.transport_ident);
			check_field("received_crc", want.received_crc, got.received_crc);
			check_field("status", want.status, got.status);
		end
	endtask

	// Monitor: both channels are sampled at the rising edge. An accepted input
	// word is predicted before any output word of the same edge is checked,
	// which is harmless since results pass the input register and the queue first.
	always @(posedge clk) begin
		in_took = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		if (in_took)
			parse_word(data_byte, last_byte);
		if (out_took)
			check_result();
	end

	// Input driver: changes the port at the falling edge. A presented word
	// stays until accepted; after each accepted word a random idle gap is
	// drawn, except during calm stretches that run back to back.
	always @(negedge clk) begin
		group_word_t w;
		logic        v;
		if (arst_n) begin
			v = in_valid;
			if (in_took) begin
				if ($urandom_range(0, 39) == 0)
					in_calm = !in_calm;
				in_gap = in_calm ? 0 : $urandom_range(0, 5);
			end
			if (!(in_valid && !in_took)) begin
				if (in_gap > 0) begin
					in_gap--;
					v = 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					data_byte <= w.value;
					last_byte <= w.final_word;
					v = 1'b1;
				end else begin
					v = 1'b0;
				end
			end
			in_valid <= v;
		end
	end

	// Output side: after each accepted result the receiver stalls for a random
	// gap, then keeps ready high until the next word is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				if ($urandom_range(0, 39) == 0)
					out_calm = !out_calm;
				out_hold = out_calm ? 0 : $urandom_range(0, 5);
			end
			if (out_hold > 0) begin
				out_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Group under five bytes, with the byte extremes in the header.
		grp = '{8'hFF, 8'h00};
		commit_group();
		// Transport id announced with an address length of one.
		grp = '{8'h10, 8'h00, 8'h11, 8'h12, 8'h34};
		commit_group();
		// Every optional field present, one address byte, one data byte and a CRC.
		grp = '{8'hF7, 8'h5A, 8'hBE, 8'hEF, 8'h80, 8'h01, 8'h13, 8'hAB, 8'hCD,
			8'h77, 8'h01, 8'hC1, 8'hC2};
		commit_group();
		// Group that ends on an address byte.
		grp = '{8'h10, 8'h00, 8'h02, 8'h11, 8'h22};
		commit_group();
		// CRC flagged, but only one byte follows the header.
		grp = '{8'hC0, 8'h00, 8'h12, 8'h34, 8'h56};
		commit_group();

		while (word_total < 1150)
			make_random_group();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		// Let any stray result surface before the verdict.
		repeat (20) @(posedge clk);

		$display("Drove %0d words in %0d groups and checked %0d results.",
			word_total, group_total, results_checked);
		$display("Summaries by status: ok %0d, too short %0d, truncated %0d, bad address length %0d.",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_TRUNC],
			status_seen[ST_ADDR_LEN]);
		if (mismatch_count == 0)
			$display("data_group_header_parser_top: match");
		else
			$display("data_group_header_parser_top: mismatch");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/dgh_pkg.sv
rtl/dgh_fifo.sv
rtl/dgh_parse.sv
rtl/data_group_header_parser_top.sv
rtl/dgh_checker.sv
dv/tb.sv
